FILE: hw/rtl/dre_pkg.sv
// Shared types and constants for the discounting rate estimator.
package dre_pkg;

    localparam int PKT_W      = 16;
    localparam int DECAY_W    = 8;
    localparam int UNIT_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int IN_USER_W  = 3;

    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(205);
    localparam logic [UNIT_W-1:0]  UNIT_RESET  = UNIT_W'(15625);

    typedef enum logic [1:0] {
        ACT_RX_PKT  = 2'd0,
        ACT_TX_PKT  = 2'd1,
        ACT_RX_TICK = 2'd2,
        ACT_TX_TICK = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_NUM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_UNIT = CFG_IDX_W'(1);

endpackage

FILE: hw/rtl/dre_decay.sv
// Bit-serial multiplier that scales a counter by a Q0.8 decay factor.
module dre_decay #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COUNT_WIDTH-1:0]      count_in,
    input  logic [dre_pkg::DECAY_W-1:0] factor,
    output logic                        done,
    output logic [COUNT_WIDTH-1:0]      product
);
    import dre_pkg::*;

    localparam int ACC_W = COUNT_WIDTH + DECAY_W;
    localparam int CNT_W = $clog2(DECAY_W);

    logic [ACC_W-1:0]       acc_reg;
    logic [COUNT_WIDTH-1:0] mult_reg;
    logic [DECAY_W-1:0]     factor_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [ACC_W-1:0]       acc_next;

    // Shift-and-add, factor bits taken from the top down.
    always_comb begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0};
        if (factor_reg[DECAY_W-1]) begin
            acc_next = acc_next + ACC_W'(mult_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= CNT_W'(DECAY_W - 1);
            acc_reg    <= '0;
            mult_reg   <= count_in;
            factor_reg <= factor;
        end else if (busy_reg) begin
            acc_reg    <= acc_next;
            factor_reg <= {factor_reg[DECAY_W-2:0], 1'b0};
            cnt_reg    <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[ACC_W-1:DECAY_W];

endmodule

FILE: hw/rtl/dre_level_div.sv
// Bit-serial restoring divider that yields a saturated congestion level.
module dre_level_div #(
    parameter int COUNT_WIDTH = 32,
    parameter int LEVEL_WIDTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [COUNT_WIDTH-1:0]     dividend,
    input  logic [dre_pkg::UNIT_W-1:0] divisor,
    output logic                       done,
    output logic [LEVEL_WIDTH-1:0]     level
);
    import dre_pkg::*;

    localparam int BASE_W = (COUNT_WIDTH > UNIT_W) ? COUNT_WIDTH : UNIT_W;
    localparam int EW     = BASE_W + LEVEL_WIDTH;
    localparam int STEP_W = $clog2(LEVEL_WIDTH);

    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [EW-1:0]          dshift_reg;
    logic [LEVEL_WIDTH-1:0] quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic          saturate;
    logic          ge;
    logic [EW-1:0] diff;

    // The quotient exceeds the level range exactly when dividend >> L >= divisor;
    // a zero divisor lands here as well.
    assign saturate = EW'(dividend >> LEVEL_WIDTH) >= EW'(divisor);
    assign ge       = EW'(rem_reg) >= dshift_reg;
    assign diff     = EW'(rem_reg) - dshift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            rem_reg    <= dividend;
            dshift_reg <= EW'(divisor) << (LEVEL_WIDTH - 1);
            step_reg   <= STEP_W'(LEVEL_WIDTH - 1);
            if (saturate) begin
                quo_reg  <= '1;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                quo_reg  <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= diff[COUNT_WIDTH-1:0];
            end
            quo_reg    <= {quo_reg[LEVEL_WIDTH-2:0], ge};
            dshift_reg <= dshift_reg >> 1;
            step_reg   <= step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign level = quo_reg;

endmodule

FILE: hw/rtl/discounting_rate_estimator.sv
// Top level of the discounting rate estimator: counters, sequencer and ports.
//
// This block keeps a receive and a transmit byte counter for one port. Each input
// beat carries an action in tuser[1:0] (received packet, sent packet, receive decay
// tick, transmit decay tick), a send-success flag in tuser[2] and a packet length
// in tdata. Packets add their length to their direction's counter, saturating at
// the counter maximum; a failed send is ignored. A decay tick scales a started
// direction's counter by decay_num/256 (floor) and is ignored before that
// direction has seen its first counted packet. Every input beat produces exactly
// one output beat holding both congestion levels, each counter / level_unit
// saturated at the level maximum (a level_unit of zero gives the maximum). One
// item is processed at a time: after accept, a decay tick of a started direction
// first runs the Q0.8 decay as a bit-serial multiply, then both levels are divided
// in parallel by restoring dividers that produce one quotient bit per cycle (a
// level that saturates skips the serial steps), and the result is loaded into the
// output register once both are done and it is free. The output register lets the
// next item be accepted while a finished result waits. The configuration channel
// is always ready and is to be written only while the block is idle.
module discounting_rate_estimator #(
    parameter int COUNT_WIDTH = 32,
    parameter int LEVEL_WIDTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dre_pkg::PKT_W-1:0]      s_axis_tdata,   // [15:0] pkt_bytes
    input  logic [dre_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [1:0] action, [2] send_ok

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [((2*LEVEL_WIDTH+7)/8)*8-1:0] m_axis_tdata, // in_level, then out_level,
                                                             // zero padded

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dre_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dre_pkg::*;

    localparam int OUT_W = ((2 * LEVEL_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECAY,
        ST_START,
        ST_DIV
    } state_t;

    state_t                 state_reg;
    logic [COUNT_WIDTH-1:0] rx_count_reg;
    logic [COUNT_WIDTH-1:0] tx_count_reg;
    logic                   rx_started_reg;
    logic                   tx_started_reg;
    logic                   decay_tx_reg;
    logic [DECAY_W-1:0]     decay_num_reg;
    logic [UNIT_W-1:0]      level_unit_reg;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    logic                   in_accept;
    action_t                action;
    logic                   send_ok;
    logic [COUNT_WIDTH:0]   rx_sum;
    logic [COUNT_WIDTH:0]   tx_sum;
    logic [COUNT_WIDTH-1:0] rx_added;
    logic [COUNT_WIDTH-1:0] tx_added;
    logic                   decay_start;
    logic                   decay_done;
    logic [COUNT_WIDTH-1:0] decay_product;
    logic                   div_start;
    logic                   rx_div_done;
    logic                   tx_div_done;
    logic [LEVEL_WIDTH-1:0] in_level;
    logic [LEVEL_WIDTH-1:0] out_level;
    logic                   out_free;
    logic                   out_load;
    logic [OUT_W-1:0]       out_word;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign action        = action_t'(s_axis_tuser[1:0]);
    assign send_ok       = s_axis_tuser[2];
    assign cfg_ready     = 1'b1;

    // Saturating packet adds; the carry out marks an overflow.
    assign rx_sum   = {1'b0, rx_count_reg} + (COUNT_WIDTH + 1)'(s_axis_tdata);
    assign tx_sum   = {1'b0, tx_count_reg} + (COUNT_WIDTH + 1)'(s_axis_tdata);
    assign rx_added = rx_sum[COUNT_WIDTH] ? '1 : rx_sum[COUNT_WIDTH-1:0];
    assign tx_added = tx_sum[COUNT_WIDTH] ? '1 : tx_sum[COUNT_WIDTH-1:0];

    // A decay tick for a started direction launches the serial multiplier
    // straight from the accepting beat.
    assign decay_start = in_accept &&
                         (((action == ACT_RX_TICK) && rx_started_reg) ||
                          ((action == ACT_TX_TICK) && tx_started_reg));

    dre_decay #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_decay (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (decay_start),
        .count_in ((action == ACT_TX_TICK) ? tx_count_reg : rx_count_reg),
        .factor   (decay_num_reg),
        .done     (decay_done),
        .product  (decay_product)
    );

    // Both levels are divided in parallel from the settled counters.
    assign div_start = (state_reg == ST_START);

    dre_level_div #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_rx_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rx_count_reg),
        .divisor  (level_unit_reg),
        .done     (rx_div_done),
        .level    (in_level)
    );

    dre_level_div #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_tx_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tx_count_reg),
        .divisor  (level_unit_reg),
        .done     (tx_div_done),
        .level    (out_level)
    );

    always_comb begin
        out_word = '0;
        out_word[LEVEL_WIDTH-1:0]             = in_level;
        out_word[2*LEVEL_WIDTH-1:LEVEL_WIDTH] = out_level;
    end

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_DIV) && rx_div_done && tx_div_done && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rx_count_reg   <= '0;
            tx_count_reg   <= '0;
            rx_started_reg <= 1'b0;
            tx_started_reg <= 1'b0;
            decay_tx_reg   <= 1'b0;
            decay_num_reg  <= DECAY_RESET;
            level_unit_reg <= UNIT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DECAY_NUM:  decay_num_reg  <= cfg_data[DECAY_W-1:0];
                    REG_LEVEL_UNIT: level_unit_reg <= cfg_data[UNIT_W-1:0];
                    default: ;
                endcase
            end

            // A new result replaces the one being drained in the same cycle.
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= out_word;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= decay_start ? ST_DECAY : ST_START;
                        decay_tx_reg <= (action == ACT_TX_TICK);
                        case (action)
                            ACT_RX_PKT: begin
                                rx_started_reg <= 1'b1;
                                rx_count_reg   <= rx_added;
                            end
                            ACT_TX_PKT: begin
                                if (send_ok) begin
                                    tx_started_reg <= 1'b1;
                                    tx_count_reg   <= tx_added;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DECAY: begin
                    if (decay_done) begin
                        if (decay_tx_reg) begin
                            tx_count_reg <= decay_product;
                        end else begin
                            rx_count_reg <= decay_product;
                        end
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // An accepted beat always leaves the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // A direction that has not started still holds a zero counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !rx_started_reg |-> (rx_count_reg == '0))
        else $error("receive counter moved before receive direction started");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !tx_started_reg |-> (tx_count_reg == '0))
        else $error("transmit counter moved before transmit direction started");

    // A new result appears only after both divisions finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DIV && rx_div_done && tx_div_done))
        else $error("result presented without completed divisions");

endmodule
